@@ hdl/mf3_pkg.sv @@
// Shared constants, types and helper functions of the 3x3 median filter.
`default_nettype none

package mf3_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int PIX_W          = 8;
  localparam int ACC_W          = 28;
  localparam int CFG_W          = 11;
  localparam int OUT_DEPTH      = 8;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [ACC_W-1:0] acc_t;
  typedef logic [CFG_W-1:0] cfg_data_t;
  typedef logic [0:0]       cfg_idx_t;

  localparam cfg_idx_t  REG_FRAME_WIDTH  = 1'b0;
  localparam cfg_idx_t  REG_FRAME_HEIGHT = 1'b1;
  localparam cfg_data_t CFG_SIZE_RESET   = 11'd1024;

  localparam logic OP_FLUSH = 1'b1;

  // [0] upper row, [1] middle row, [2] lower row
  typedef pix_t [2:0] column_t;

  typedef struct packed {
    logic last;
    pix_t fmax;
    pix_t fmin;
  } tag_t;

  typedef struct packed {
    logic    vld;
    column_t left;
    column_t center;
    column_t right;
    tag_t    tag;
  } med_req_t;

  typedef struct packed {
    logic vld;
    pix_t med;
    pix_t orig;
    tag_t tag;
  } med_rsp_t;

  typedef struct packed {
    pix_t med;
    logic last;
    pix_t fmax;
    pix_t fmin;
    acc_t acc;
  } out_word_t;

  function automatic pix_t pmin(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t pmax(pix_t a, pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return pmax(pmin(a, b), pmin(pmax(a, b), c));
  endfunction

endpackage

`default_nettype wire

@@ hdl/mf3_if.sv @@
// Valid/ready stream interfaces for the filter's pixel input and result output.
`default_nettype none

interface mf3_in_if;
  import mf3_pkg::*;

  logic valid;
  logic ready;
  logic operation;
  pix_t pixel_value;

  modport source (output valid, operation, pixel_value, input ready);
  modport sink (input valid, operation, pixel_value, output ready);
endinterface

interface mf3_out_if;
  import mf3_pkg::*;

  logic valid;
  logic ready;
  pix_t median_value;
  logic last_of_frame;
  pix_t frame_max;
  pix_t frame_min;
  acc_t abs_error_sum;

  modport source (output valid, median_value, last_of_frame, frame_max, frame_min,
                  abs_error_sum, input ready);
  modport sink (input valid, median_value, last_of_frame, frame_max, frame_min,
                abs_error_sum, output ready);
endinterface

`default_nettype wire

@@ hdl/mf3_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hdl/mf3_median.sv @@
// Three-stage median-of-nine pipeline: column sort, row reduce, final med3.
`default_nettype none

module mf3_median (
  input  logic              clk,
  input  logic              rst_n,
  input  mf3_pkg::med_req_t req,
  output mf3_pkg::med_rsp_t rsp
);
  import mf3_pkg::*;

  column_t [2:0] cols;
  pix_t [2:0]    lo_nxt, mi_nxt, hi_nxt;
  pix_t [2:0]    a_lo_r, a_mi_r, a_hi_r;
  logic          a_vld_r, b_vld_r, c_vld_r;
  tag_t          a_tag_r, b_tag_r, c_tag_r;
  pix_t          a_orig_r, b_orig_r, c_orig_r;
  pix_t          b_lo_r, b_mi_r, b_hi_r;
  pix_t          c_med_r;

  assign cols = {req.right, req.center, req.left};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_nxt[i] = pmin(pmin(cols[i][0], cols[i][1]), cols[i][2]);
      mi_nxt[i] = med3(cols[i][0], cols[i][1], cols[i][2]);
      hi_nxt[i] = pmax(pmax(cols[i][0], cols[i][1]), cols[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= req.vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_lo_r   <= lo_nxt;
    a_mi_r   <= mi_nxt;
    a_hi_r   <= hi_nxt;
    a_tag_r  <= req.tag;
    a_orig_r <= req.center[1];

    // median of nine = med3(max of lows, med of mids, min of highs)
    b_lo_r   <= pmax(pmax(a_lo_r[0], a_lo_r[1]), a_lo_r[2]);
    b_mi_r   <= med3(a_mi_r[0], a_mi_r[1], a_mi_r[2]);
    b_hi_r   <= pmin(pmin(a_hi_r[0], a_hi_r[1]), a_hi_r[2]);
    b_tag_r  <= a_tag_r;
    b_orig_r <= a_orig_r;

    c_med_r  <= med3(b_lo_r, b_mi_r, b_hi_r);
    c_tag_r  <= b_tag_r;
    c_orig_r <= b_orig_r;
  end

  assign rsp = '{vld: c_vld_r, med: c_med_r, orig: c_orig_r, tag: c_tag_r};

endmodule

`default_nettype wire

@@ hdl/median_filter_3x3_zero_pad_top.sv @@
// Top level of the streaming 3x3 zero-padded median filter.
// Usage:
//   in_if  : one word per pixel in raster order (operation 0), then width+1
//            flush words (operation 1). A flush word before the frame's last
//            pixel is taken and dropped; a pixel word after it counts as flush.
//   out_if : one median per frame position, raster order; the word for pixel k
//            is caused by input word k+width+1. The word with last_of_frame set
//            carries frame max, frame min and the sum of |pixel - median|;
//            these fields read zero on all other words.
//   cfg_*  : frame_width (index 0) and frame_height (index 1), clamped to
//            1..MAX_WIDTH and 1..MAX_HEIGHT, sampled when a frame's first word
//            is taken.
// Throughput: one word per cycle while in_if.ready is high, set by the two-row line
//   buffer RAM, read and written once per word (forwarded when one column repeats).
// Path to out_if: line buffer stage, window registers, median pipeline, output queue.
// Reset (rst_n low, synchronous) starts a new frame and empties the output
//   queue; configuration returns to 1024 x 1024.
// A stalled receiver fills an 8-word output queue; in_if.ready drops once 8
//   results are accepted but not yet delivered.
`default_nettype none

module median_filter_3x3_zero_pad_top #(
  parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  mf3_in_if.sink             in_if,
  mf3_out_if.source          out_if,
  input  logic               cfg_wr_en,
  input  mf3_pkg::cfg_idx_t  cfg_index,
  input  mf3_pkg::cfg_data_t cfg_wdata
);
  import mf3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int OB = $clog2(OUT_DEPTH);
  localparam int CB = $clog2(OUT_DEPTH + 1);

  // configuration
  cfg_data_t cfg_width_r, cfg_height_r;
  logic [WW-1:0] clamp_w, cur_w_r, w_eff;
  logic [RW-1:0] clamp_h, cur_h_r, h_eff;

  // frame position and statistics
  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  pix_t          max_r, min_r;
  logic          frame_start, in_pixels, accept, skip, take;
  logic          col_end, has_res, is_last;
  pix_t          in_val;

  // line buffer stage
  logic             s1_vld_r;
  logic [AW-1:0]    s1_addr_r;
  pix_t             s1_v_r;
  logic             s1_ge1_r, s1_ge2_r, s1_cz_r, s1_res_r, s1_fwd_r;
  logic [2*PIX_W-1:0] s1_fwd_data_r, lb_rdata, lb_rd, lb_wdata;
  tag_t             s1_tag_r, tag_nxt;
  column_t          new_col;

  // window
  column_t  win_l_r, win_c_r, win_r_r;
  logic     cz_c_r, cz_r_r;
  logic     s2_vld_r;
  tag_t     s2_tag_r;
  med_req_t req;
  med_rsp_t rsp;

  // output queue
  out_word_t     fifo_mem [OUT_DEPTH];
  out_word_t     head;
  logic [OB-1:0] wr_ptr_r, rd_ptr_r;
  logic [CB-1:0] fifo_cnt_r, credit_r;
  acc_t          acc_r, acc_sum;
  pix_t          diff;
  logic          pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CFG_SIZE_RESET;
      cfg_height_r <= CFG_SIZE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: cfg_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width_r == '0) begin
      clamp_w = WW'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      clamp_w = WW'(MAX_WIDTH);
    end else begin
      clamp_w = WW'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      clamp_h = RW'(1);
    end else if (32'(cfg_height_r) > 32'(MAX_HEIGHT)) begin
      clamp_h = RW'(MAX_HEIGHT);
    end else begin
      clamp_h = RW'(cfg_height_r);
    end
  end

  assign frame_start = (row_r == '0) && (col_r == '0);
  assign w_eff       = frame_start ? clamp_w : cur_w_r;
  assign h_eff       = frame_start ? clamp_h : cur_h_r;
  assign in_pixels   = row_r < h_eff;
  assign accept      = in_if.valid && in_if.ready;
  assign skip        = in_pixels && (in_if.operation == OP_FLUSH);
  assign take        = accept && !skip;
  assign in_val      = in_pixels ? in_if.pixel_value : '0;
  assign col_end     = WW'(col_r) == (w_eff - WW'(1));
  assign has_res     = (row_r > RW'(1)) || ((row_r == RW'(1)) && (col_r != '0));
  assign is_last     = (row_r == (h_eff + RW'(1))) && (col_r == '0);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (take) begin
      if (is_last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_end) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_comb begin
    tag_nxt.last = is_last;
    tag_nxt.fmax = is_last ? max_r : '0;
    tag_nxt.fmin = is_last ? min_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      max_r    <= '0;
      min_r    <= '1;
      s1_vld_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_vld_r <= take;
      if (take && is_last) begin
        max_r <= '0;
        min_r <= '1;
      end else if (take && in_pixels) begin
        max_r <= pmax(max_r, in_if.pixel_value);
        min_r <= pmin(min_r, in_if.pixel_value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_w_r <= w_eff;
      cur_h_r <= h_eff;
    end
    if (take) begin
      s1_addr_r     <= col_r;
      s1_v_r        <= in_val;
      s1_ge1_r      <= row_r != '0;
      s1_ge2_r      <= row_r > RW'(1);
      s1_cz_r       <= col_r == '0;
      s1_res_r      <= has_res;
      s1_tag_r      <= tag_nxt;
      s1_fwd_r      <= s1_vld_r && (s1_addr_r == col_r);
      s1_fwd_data_r <= lb_wdata;
    end
  end

  // line buffer word: {value two rows up, value one row up}
  mf3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (s1_vld_r),
    .wr_addr (s1_addr_r),
    .wr_data (lb_wdata),
    .rd_addr (col_r),
    .rd_data (lb_rdata)
  );

  assign lb_rd      = s1_fwd_r ? s1_fwd_data_r : lb_rdata;
  assign lb_wdata   = {lb_rd[PIX_W-1:0], s1_v_r};
  assign new_col[0] = s1_ge2_r ? lb_rd[2*PIX_W-1:PIX_W] : '0;
  assign new_col[1] = s1_ge1_r ? lb_rd[PIX_W-1:0] : '0;
  assign new_col[2] = s1_v_r;

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      win_l_r <= win_c_r;
      win_c_r <= win_r_r;
      win_r_r <= new_col;
      cz_c_r  <= cz_r_r;
      cz_r_r  <= s1_cz_r;
    end
    s2_tag_r <= s1_tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r && s1_res_r;
    end
  end

  // left column is off frame when center is column 0, right when right is column 0
  assign req = '{vld:    s2_vld_r,
                 left:   cz_c_r ? '0 : win_l_r,
                 center: win_c_r,
                 right:  cz_r_r ? '0 : win_r_r,
                 tag:    s2_tag_r};

  mf3_median u_median (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign diff    = (rsp.orig > rsp.med) ? (rsp.orig - rsp.med) : (rsp.med - rsp.orig);
  assign acc_sum = acc_r + ACC_W'(diff);
  assign pop     = out_if.valid && out_if.ready;

  always_ff @(posedge clk) begin
    if (rsp.vld) begin
      fifo_mem[wr_ptr_r] <= '{med:  rsp.med,
                              last: rsp.tag.last,
                              fmax: rsp.tag.fmax,
                              fmin: rsp.tag.fmin,
                              acc:  rsp.tag.last ? acc_sum : '0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      credit_r   <= '0;
      acc_r      <= '0;
    end else begin
      if (rsp.vld) begin
        wr_ptr_r <= (wr_ptr_r == OB'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + OB'(1);
        acc_r    <= rsp.tag.last ? '0 : acc_sum;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == OB'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + OB'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + CB'(rsp.vld) - CB'(pop);
      credit_r   <= credit_r + CB'(take && has_res) - CB'(pop);
    end
  end

  assign head                 = fifo_mem[rd_ptr_r];
  assign in_if.ready          = credit_r < CB'(OUT_DEPTH);
  assign out_if.valid         = fifo_cnt_r != '0;
  assign out_if.median_value  = head.med;
  assign out_if.last_of_frame = head.last;
  assign out_if.frame_max     = head.fmax;
  assign out_if.frame_min     = head.fmin;
  assign out_if.abs_error_sum = head.acc;

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.vld |-> fifo_cnt_r < CB'(OUT_DEPTH))
    else $error("result queue written while full");

  a_credit_cover: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r >= fifo_cnt_r)
    else $error("outstanding count below queue fill");

  a_stats_last_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.last_of_frame) |->
      (out_if.frame_max == '0) && (out_if.frame_min == '0) && (out_if.abs_error_sum == '0))
    else $error("frame statistics on a non-final word");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && is_last) |=> (row_r == '0) && (col_r == '0) && (max_r == '0) && (min_r == '1))
    else $error("frame state not restarted after final word");

endmodule

`default_nettype wire
